// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl top level of the point to segment distance block
// no dependencies; include by bare file name inside a module body
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// overlapping implication, checked out of reset
`define PSD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// non-overlapping implication, checked out of reset
`define PSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/psd_pkg.sv =====
// package for the point to segment distance block: widths, constants, types
// no dependencies
package psd_pkg;

    localparam int PSD_CW    = 16;  // input coordinate width
    localparam int PSD_DW    = 17;  // difference width
    localparam int PSD_PW    = 34;  // width of a squared difference
    localparam int PSD_L2W   = 34;  // squared length width, unsigned
    localparam int PSD_DOTW  = 35;  // dot product width, signed
    localparam int PSD_QW    = 16;  // quotient bits of the projection
    localparam int PSD_UW    = 17;  // projection parameter incl. 1.0
    localparam int PSD_EW    = 27;  // error vector component width
    localparam int PSD_NW    = 54;  // radicand width, even
    localparam int PSD_RW    = PSD_NW / 2;
    localparam int PSD_OW    = 17;  // distance width
    localparam int PSD_FRAC  = 8;   // root fraction bits dropped to get an unsigned q17.0 distance

    localparam logic [PSD_UW-1:0] PSD_U_ONE  = 17'd65536;
    localparam logic [PSD_UW-1:0] PSD_U_ZERO = 17'd0;

    // geometry riding along with the divider
    typedef struct packed {
        logic                      zero;  // projection clamps to 0
        logic                      one;   // projection clamps to 1.0
        logic signed [PSD_DW-1:0]  dx;
        logic signed [PSD_DW-1:0]  dy;
        logic signed [PSD_DW-1:0]  wx;
        logic signed [PSD_DW-1:0]  wy;
    } t_psd_geom;

endpackage

// ===== hw/rtl/point_segment_distance.sv =====
// top level of the point to segment distance block
// depends on psd_pkg, psd_div, psd_sqrt and assert_macros.svh
//
//   channel | dir | handshake                    | payload
//   input   | in  | i_in_valid / o_in_ready      | i_seg_ax..i_seg_by, i_point_x, i_point_y
//   output  | out | o_out_valid / i_out_ready    | o_distance
//
// one beat in per cycle while the output is not stalled; 8 arithmetic stages,
// 16 divider stages and 27 square root stages, the last of them is the output register
// reset clears only the valid bits of the pipeline
// a stalled output beat freezes the whole pipeline; nothing is dropped or repeated
module point_segment_distance (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic signed [psd_pkg::PSD_CW-1:0] i_seg_ax,
    input  logic signed [psd_pkg::PSD_CW-1:0] i_seg_ay,
    input  logic signed [psd_pkg::PSD_CW-1:0] i_seg_bx,
    input  logic signed [psd_pkg::PSD_CW-1:0] i_seg_by,
    input  logic signed [psd_pkg::PSD_CW-1:0] i_point_x,
    input  logic signed [psd_pkg::PSD_CW-1:0] i_point_y,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [psd_pkg::PSD_OW-1:0]        o_distance
);
    import psd_pkg::*;
    `include "assert_macros.svh"

    logic en;
    assign en         = !o_out_valid || i_out_ready;
    assign o_in_ready = en;

    // stage 1: differences
    logic r_v1;
    logic signed [PSD_DW-1:0] r_dx1, r_dy1, r_wx1, r_wy1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dx1 <= PSD_DW'(i_seg_bx) - PSD_DW'(i_seg_ax);
            r_dy1 <= PSD_DW'(i_seg_by) - PSD_DW'(i_seg_ay);
            r_wx1 <= PSD_DW'(i_point_x) - PSD_DW'(i_seg_ax);
            r_wy1 <= PSD_DW'(i_point_y) - PSD_DW'(i_seg_ay);
        end
    end

    // stage 2: products
    logic r_v2;
    logic signed [PSD_DW-1:0] r_dx2, r_dy2, r_wx2, r_wy2;
    logic signed [PSD_PW-1:0] r_dxx, r_dyy, r_wdx, r_wdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dxx <= r_dx1 * r_dx1;
            r_dyy <= r_dy1 * r_dy1;
            r_wdx <= r_wx1 * r_dx1;
            r_wdy <= r_wy1 * r_dy1;
            r_dx2 <= r_dx1;
            r_dy2 <= r_dy1;
            r_wx2 <= r_wx1;
            r_wy2 <= r_wy1;
        end
    end

    // stage 3: squared length, dot product and clamp decisions
    logic r_v3;
    logic [PSD_L2W-1:0] r_len2;
    logic [PSD_L2W-1:0] r_num;
    t_psd_geom r_geo3;
    logic signed [PSD_DOTW-1:0] n_dot;
    logic signed [PSD_DOTW-1:0] n_len2;

    assign n_len2 = PSD_DOTW'(r_dxx) + PSD_DOTW'(r_dyy);
    assign n_dot  = PSD_DOTW'(r_wdx) + PSD_DOTW'(r_wdy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v3 <= r_v2;
        end
    end

    // clamp to 0 for a zero-length segment or a dot at or below zero: sign bit set or all bits clear
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_len2      <= n_len2[PSD_L2W-1:0];
            r_num       <= n_dot[PSD_L2W-1:0];
            r_geo3.zero <= (n_len2 == '0) || n_dot[PSD_DOTW-1] || (n_dot == '0);
            r_geo3.one  <= (n_dot >= n_len2);
            r_geo3.dx   <= r_dx2;
            r_geo3.dy   <= r_dy2;
            r_geo3.wx   <= r_wx2;
            r_geo3.wy   <= r_wy2;
        end
    end

    // projection quotient; numerator is only meaningful when not clamped
    logic              div_v;
    logic [PSD_QW-1:0] div_q;
    t_psd_geom         div_geo;
    logic [PSD_L2W-1:0] div_num;

    assign div_num = (r_geo3.zero || r_geo3.one) ? '0 : r_num;

    psd_div #(
        .NumW  (PSD_L2W),
        .QuoW  (PSD_QW),
        .SideW ($bits(t_psd_geom))
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_v3),
        .i_num   (div_num),
        .i_den   (r_len2),
        .i_side  (r_geo3),
        .o_valid (div_v),
        .o_quot  (div_q),
        .o_side  (div_geo)
    );

    // clamp the projection parameter
    logic r_vu;
    logic [PSD_UW-1:0] r_u;
    t_psd_geom r_geou;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vu <= 1'b0;
        end else if (en) begin
            r_vu <= div_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            priority if (div_geo.zero) begin
                r_u <= PSD_U_ZERO;
            end else if (div_geo.one) begin
                r_u <= PSD_U_ONE;
            end else begin
                r_u <= {1'b0, div_q};
            end
            r_geou <= div_geo;
        end
    end

    // offset u*d in units of 2^-16
    localparam int MW = PSD_UW + 1 + PSD_DW;
    logic r_vm;
    logic signed [MW-1:0] r_px, r_py;
    logic signed [PSD_DW-1:0] r_wxm, r_wym;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vm <= 1'b0;
        end else if (en) begin
            r_vm <= r_vu;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_px  <= $signed({1'b0, r_u}) * r_geou.dx;
            r_py  <= $signed({1'b0, r_u}) * r_geou.dy;
            r_wxm <= r_geou.wx;
            r_wym <= r_geou.wy;
        end
    end

    // error vector in signed q19.8, offset floored to 2^-8
    logic r_ve;
    logic signed [PSD_EW-1:0] r_ex, r_ey;
    logic signed [PSD_EW:0] n_ex, n_ey;
    logic signed [MW-1:0] n_ox, n_oy;

    assign n_ox = r_px >>> PSD_FRAC;
    assign n_oy = r_py >>> PSD_FRAC;
    assign n_ex = (PSD_EW+1)'(n_ox) - ((PSD_EW+1)'(r_wxm) <<< PSD_FRAC);
    assign n_ey = (PSD_EW+1)'(n_oy) - ((PSD_EW+1)'(r_wym) <<< PSD_FRAC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ve <= 1'b0;
        end else if (en) begin
            r_ve <= r_vm;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ex <= n_ex[PSD_EW-1:0];
            r_ey <= n_ey[PSD_EW-1:0];
        end
    end

    // squares
    logic r_vq;
    logic signed [2*PSD_EW-1:0] r_exx, r_eyy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vq <= 1'b0;
        end else if (en) begin
            r_vq <= r_ve;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_exx <= r_ex * r_ex;
            r_eyy <= r_ey * r_ey;
        end
    end

    // squared distance
    logic r_vs;
    logic [PSD_NW-1:0] r_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vs <= 1'b0;
        end else if (en) begin
            r_vs <= r_vq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum <= PSD_NW'(r_exx) + PSD_NW'(r_eyy);
        end
    end

    // root, last stage is the output register
    logic [PSD_RW-1:0] root;

    psd_sqrt #(
        .NumW  (PSD_NW),
        .RootW (PSD_RW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_vs),
        .i_rad   (r_sum),
        .o_valid (o_out_valid),
        .o_root  (root)
    );

    assign o_distance = root[PSD_FRAC+PSD_OW-1:PSD_FRAC];

    // both clamp flags are set together only for a zero-length segment
    `PSD_ASSERT_NOW(a_clamp_excl, i_clk, i_rst_n, r_v3, !(r_geo3.zero && r_geo3.one && r_len2 != '0))
    // projection parameter never exceeds 1.0
    `PSD_ASSERT_NOW(a_u_range, i_clk, i_rst_n, r_vu, r_u <= PSD_U_ONE)
    // a frozen pipeline keeps the squared distance
    `PSD_ASSERT_NEXT(a_sum_hold, i_clk, i_rst_n, r_vs && !en, $stable(r_sum) && r_vs)

endmodule

// ===== hw/rtl/psd_div.sv =====
// pipelined restoring divider, one quotient bit per stage, side data carried along
// depends on psd_pkg
module psd_div #(
    parameter int NumW  = psd_pkg::PSD_L2W,
    parameter int QuoW  = psd_pkg::PSD_QW,
    parameter int SideW = $bits(psd_pkg::t_psd_geom)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NumW-1:0]  i_num,   // must be below i_den
    input  logic [NumW-1:0]  i_den,
    input  logic [SideW-1:0] i_side,
    output logic             o_valid,
    output logic [QuoW-1:0]  o_quot,
    output logic [SideW-1:0] o_side
);
    import psd_pkg::*;

    logic [QuoW-1:0]  r_v;
    logic [NumW-1:0]  r_rem  [QuoW];
    logic [NumW-1:0]  r_den  [QuoW];
    logic [QuoW-1:0]  r_q    [QuoW];
    logic [SideW-1:0] r_side [QuoW];

    genvar k;
    generate
        for (k = 0; k < QuoW; k++) begin : g_stage
            logic             p_v;
            logic [NumW-1:0]  p_rem;
            logic [NumW-1:0]  p_den;
            logic [QuoW-1:0]  p_q;
            logic [SideW-1:0] p_side;
            logic [NumW:0]    t;
            logic [NumW:0]    diff;
            logic             ge;

            // previous stage or the input port
            if (k == 0) begin : g_first
                assign p_v    = i_valid;
                assign p_rem  = i_num;
                assign p_den  = i_den;
                assign p_q    = '0;
                assign p_side = i_side;
            end else begin : g_next
                assign p_v    = r_v[k-1];
                assign p_rem  = r_rem[k-1];
                assign p_den  = r_den[k-1];
                assign p_q    = r_q[k-1];
                assign p_side = r_side[k-1];
            end

            // shift, trial subtract
            assign t    = {p_rem, 1'b0};
            assign diff = t - {1'b0, p_den};
            assign ge   = (t >= {1'b0, p_den});

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= p_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= ge ? diff[NumW-1:0] : t[NumW-1:0];
                    r_den[k]  <= p_den;
                    r_q[k]    <= {p_q[QuoW-2:0], ge};
                    r_side[k] <= p_side;
                end
            end
        end
    endgenerate

    assign o_valid = r_v[QuoW-1];
    assign o_quot  = r_q[QuoW-1];
    assign o_side  = r_side[QuoW-1];

endmodule

// ===== hw/rtl/psd_sqrt.sv =====
// pipelined integer square root, one root bit per stage
// depends on psd_pkg
module psd_sqrt #(
    parameter int NumW = psd_pkg::PSD_NW,
    parameter int RootW = NumW / 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [NumW-1:0]  i_rad,
    output logic             o_valid,
    output logic [RootW-1:0] o_root
);
    import psd_pkg::*;

    logic [RootW-1:0] r_v;
    logic [RootW+1:0] r_rem  [RootW];
    logic [RootW-1:0] r_root [RootW];
    logic [NumW-1:0]  r_n    [RootW];

    genvar k;
    generate
        for (k = 0; k < RootW; k++) begin : g_stage
            logic             p_v;
            logic [RootW+1:0] p_rem;
            logic [RootW-1:0] p_root;
            logic [NumW-1:0]  p_n;
            logic [RootW+3:0] t;
            logic [RootW+3:0] trial;
            logic [RootW+3:0] diff;
            logic             ge;

            if (k == 0) begin : g_first
                assign p_v    = i_valid;
                assign p_rem  = '0;
                assign p_root = '0;
                assign p_n    = i_rad;
            end else begin : g_next
                assign p_v    = r_v[k-1];
                assign p_rem  = r_rem[k-1];
                assign p_root = r_root[k-1];
                assign p_n    = r_n[k-1];
            end

            // bring down two bits, trial subtract 4*root+1
            assign t     = {p_rem, p_n[NumW-1:NumW-2]};
            assign trial = {2'b00, p_root, 2'b01};
            assign diff  = t - trial;
            assign ge    = (t >= trial);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else if (i_en) begin
                    r_v[k] <= p_v;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= ge ? diff[RootW+1:0] : t[RootW+1:0];
                    r_root[k] <= {p_root[RootW-2:0], ge};
                    r_n[k]    <= {p_n[NumW-3:0], 2'b00};
                end
            end
        end
    endgenerate

    assign o_valid = r_v[RootW-1];
    assign o_root  = r_root[RootW-1];

endmodule

// ===== tb/tb_point_segment_distance.sv =====
// testbench for the point to segment distance block: directed and random geometry
// depends on psd_pkg and point_segment_distance; self-contained predictor inside
module tb_point_segment_distance;
    import psd_pkg::*;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_in_valid;
    logic                      o_in_ready;
    logic signed [PSD_CW-1:0]  i_seg_ax, i_seg_ay, i_seg_bx, i_seg_by;
    logic signed [PSD_CW-1:0]  i_point_x, i_point_y;
    logic                      o_out_valid;
    logic                      i_out_ready;
    logic [PSD_OW-1:0]         o_distance;

    localparam int LATENCY = 51;

    typedef struct {
        logic signed [PSD_CW-1:0] ax, ay, bx, by, px, py;
    } t_query;

    logic [PSD_OW-1:0] dist_queue[$];
    int  n_errors    = 0;
    int  n_sent      = 0;
    int  n_checked   = 0;
    int  n_degen     = 0;
    bit  long_hold   = 0;

    point_segment_distance uut (.*);

    // clock
    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // overall time limit
    initial begin
        #4000000;
        $display("timeout");
        $display("Simulation FAILED");
        $finish;
    end

    // integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    -= root + bitv;
                root  = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    // expected distance from point to segment, unsigned q17.0 truncated
    function automatic logic [PSD_OW-1:0] seg_distance(t_query q);
        longint dx, dy, wx, wy, len2, dot, u, ox, oy, ex, ey;
        longint unsigned sum;
        dx   = longint'(q.bx) - longint'(q.ax);
        dy   = longint'(q.by) - longint'(q.ay);
        wx   = longint'(q.px) - longint'(q.ax);
        wy   = longint'(q.py) - longint'(q.ay);
        len2 = dx * dx + dy * dy;
        dot  = wx * dx + wy * dy;
        if (len2 == 0 || dot <= 0) u = 0;
        else if (dot >= len2)      u = 65536;
        else                       u = (dot * 65536) / len2;
        // arithmetic shift floors toward minus infinity
        ox  = (u * dx) >>> 8;
        oy  = (u * dy) >>> 8;
        ex  = ox - wx * 256;
        ey  = oy - wy * 256;
        sum = longint'(ex * ex) + longint'(ey * ey);
        return PSD_OW'(int_sqrt(sum) >> 8);
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        n_errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    endtask

    // send one beat and queue its expected distance; valid stays up for the next beat
    task automatic send_query(t_query q, bit allow_gap);
        int gap;
        logic [PSD_OW-1:0] want;
        gap = allow_gap ? $urandom_range(0, 8) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_seg_ax   <= q.ax;
        i_seg_ay   <= q.ay;
        i_seg_bx   <= q.bx;
        i_seg_by   <= q.by;
        i_point_x  <= q.px;
        i_point_y  <= q.py;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        want = seg_distance(q);
        dist_queue.push_back(want);
        n_sent++;
        if (q.ax == q.bx && q.ay == q.by) n_degen++;
    endtask

    // receiver stalls; one long hold while the sender keeps pushing
    bit rx_random = 0;
    initial begin
        int stall;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (150) @(posedge i_clk);
                long_hold = 0;
                i_out_ready <= 1'b1;
            end else if (rx_random) begin
                stall = $urandom_range(0, 8);
                if (stall != 0) begin
                    i_out_ready <= 1'b0;
                    repeat (stall) @(posedge i_clk);
                end
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // check each accepted result beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (dist_queue.size() == 0) begin
                report_mismatch("unexpected beat", o_distance, -1);
            end else begin
                logic [PSD_OW-1:0] want;
                want = dist_queue.pop_front();
                n_checked++;
                if (o_distance !== want) report_mismatch("distance", o_distance, want);
            end
        end
    end

    function automatic t_query mk(int ax, int ay, int bx, int by, int px, int py);
        t_query q;
        q.ax = PSD_CW'(ax); q.ay = PSD_CW'(ay); q.bx = PSD_CW'(bx);
        q.by = PSD_CW'(by); q.px = PSD_CW'(px); q.py = PSD_CW'(py);
        return q;
    endfunction

    function automatic logic signed [PSD_CW-1:0] rnd_coord();
        case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return PSD_CW'($urandom_range(0, 1023) - 512);
            default: return PSD_CW'($urandom);
        endcase
    endfunction

    // extremes, degenerate segment, clamps at both ends
    task automatic test_directed();
        send_query(mk(0, 0, 0, 0, 0, 0), 0);
        send_query(mk(-32768, -32768, -32768, -32768, 32767, 32767), 0);
        send_query(mk(32767, 32767, 32767, 32767, -32768, -32768), 0);
        send_query(mk(-32768, -32768, 32767, 32767, 32767, -32768), 0);
        send_query(mk(-32768, 32767, 32767, -32768, -32768, -32768), 0);
        send_query(mk(0, 0, 256, 0, -512, 300), 0);     // before start
        send_query(mk(0, 0, 256, 0, 1024, -300), 0);    // beyond end
        send_query(mk(0, 0, 256, 0, 128, 256), 0);      // interior
        send_query(mk(0, 0, 3, 7, 1, 1), 0);
        send_query(mk(100, 100, 100, 100, -100, -100), 0);
        send_query(mk(-1, -1, 0, 0, -1, 0), 0);
        send_query(mk(32767, -32768, -32768, 32767, 0, 0), 1);
        send_query(mk(-32768, 0, 32767, 0, 0, 32767), 1);
        send_query(mk(0, -32768, 0, 32767, -32768, 32767), 1);
        send_query(mk(-21846, 21845, 21845, -21846, -1, 1), 1);
    endtask

    // random geometry with random gaps on both sides
    task automatic test_random(int count);
        t_query q;
        rx_random = 1;
        repeat (count) begin
            q.ax = rnd_coord(); q.ay = rnd_coord();
            if ($urandom_range(0, 15) == 0) begin
                q.bx = q.ax; q.by = q.ay;
            end else begin
                q.bx = rnd_coord(); q.by = rnd_coord();
            end
            q.px = rnd_coord(); q.py = rnd_coord();
            send_query(q, $urandom_range(0, 3) != 0);
        end
    endtask

    // receiver holds off while the sender streams, filling the pipeline
    task automatic test_backpressure(int count);
        t_query q;
        long_hold = 1;
        repeat (count) begin
            q.ax = PSD_CW'($urandom); q.ay = PSD_CW'($urandom); q.bx = PSD_CW'($urandom);
            q.by = PSD_CW'($urandom); q.px = PSD_CW'($urandom); q.py = PSD_CW'($urandom);
            send_query(q, 0);
        end
    endtask

    initial begin
        int waited;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_seg_ax   <= '0; i_seg_ay  <= '0; i_seg_bx <= '0; i_seg_by <= '0;
        i_point_x  <= '0; i_point_y <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(450);
        test_backpressure(120);
        test_random(380);
        i_in_valid <= 1'b0;

        waited = 0;
        while (dist_queue.size() != 0 && waited < 100000) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (LATENCY + 10) @(posedge i_clk);
        if (dist_queue.size() != 0)
            report_mismatch("results left over", dist_queue.size(), 0);

        $display("covered %0d queries (%0d zero-length segments), %0d results checked",
                 n_sent, n_degen, n_checked);
        $display("random gaps, stalls and one long output hold-off exercised");
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
